[rtl/abo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_pkg
// Shared constants, register codes and types of the alpha-blend overlay
// compositor.
// ----------------------------------------------------------------------------
package abo_pkg;

    // pixels carried by one beat
    localparam int LANES            = 4;
    localparam int COORD_BITS_DEF   = 12;

    // pixel packing
    localparam int CHAN_W           = 8;
    localparam int IN_PIX_W         = 32;
    localparam int OUT_PIX_W        = 24;
    localparam int PROD_W           = 2 * CHAN_W;
    localparam int ALPHA_LSB        = 24;

    // register file
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 13;
    localparam int DIM_W            = 13;
    localparam int POS_W            = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_WINDOW_LEFT   = 3'd2,
        CFG_WINDOW_TOP    = 3'd3,
        CFG_WINDOW_WIDTH  = 3'd4,
        CFG_WINDOW_HEIGHT = 3'd5
    } cfg_idx_t;

    // register reset values
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd800;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd600;
    localparam logic [POS_W-1:0] RST_WINDOW_LEFT   = 12'd252;
    localparam logic [POS_W-1:0] RST_WINDOW_TOP    = 12'd424;
    localparam logic [DIM_W-1:0] RST_WINDOW_WIDTH  = 13'd235;
    localparam logic [DIM_W-1:0] RST_WINDOW_HEIGHT = 13'd126;

    // row status of the beat being accepted
    typedef struct packed {
        logic row_in;
        logic row_end;
        logic frame_end;
    } pos_t;

endpackage

[rtl/abo_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_lane
// One pixel lane: window test on its column, per-channel products in the
// first stage, sum, scale and pass-through select in the second.
// ----------------------------------------------------------------------------
module abo_lane #(
    parameter int LANE_IDX = 0,
    parameter int CMP_W    = 14
) (
    input  logic                           aclk,
    input  logic                           stage1_en,
    input  logic                           stage2_en,
    input  logic [CMP_W-1:0]               col,
    input  logic [CMP_W-1:0]               win_left,
    input  logic [CMP_W-1:0]               win_right,
    input  logic                           row_in,
    input  logic [abo_pkg::IN_PIX_W-1:0]   back_pixel,
    input  logic [abo_pkg::IN_PIX_W-1:0]   front_pixel,
    output logic [abo_pkg::OUT_PIX_W-1:0]  out_pixel
);
    import abo_pkg::*;

    localparam int NCH = 3;

    logic [CMP_W-1:0]     x;
    logic                 in_win;
    logic [CHAN_W-1:0]    alpha;
    logic [CHAN_W-1:0]    alpha_inv;

    logic                 in_win_reg;
    logic [OUT_PIX_W-1:0] back_reg;
    logic [PROD_W-1:0]    prod_f_reg [NCH];
    logic [PROD_W-1:0]    prod_b_reg [NCH];

    logic [OUT_PIX_W-1:0] blended;
    logic [OUT_PIX_W-1:0] out_pixel_reg;
    logic [OUT_PIX_W-1:0] out_pixel_next;

    // window test for this lane's column
    assign x         = col + CMP_W'(LANE_IDX);
    assign in_win    = row_in && (x >= win_left) && (x < win_right);
    assign alpha     = front_pixel[ALPHA_LSB +: CHAN_W];
    assign alpha_inv = ~alpha;

    // stage 1: products per channel
    always_ff @(posedge aclk) begin
        if (stage1_en) begin
            in_win_reg <= in_win;
            back_reg   <= back_pixel[OUT_PIX_W-1:0];
            for (int c = 0; c < NCH; c++) begin
                prod_f_reg[c] <= front_pixel[c*CHAN_W +: CHAN_W] * alpha;
                prod_b_reg[c] <= back_pixel[c*CHAN_W +: CHAN_W] * alpha_inv;
            end
        end
    end

    // sum and drop the low byte
    always_comb begin
        logic [PROD_W:0] sum;
        for (int c = 0; c < NCH; c++) begin
            sum = {1'b0, prod_f_reg[c]} + {1'b0, prod_b_reg[c]};
            blended[c*CHAN_W +: CHAN_W] = sum[CHAN_W +: CHAN_W];
        end
    end

    assign out_pixel_next = in_win_reg ? blended : back_reg;

    // stage 2: output register
    always_ff @(posedge aclk) begin
        if (stage2_en) begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_pixel = out_pixel_reg;

endmodule

[rtl/abo_position.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_position
// Column and row counters of the raster, row window test and row / frame end
// flags of the beat at the input.
// ----------------------------------------------------------------------------
module abo_position #(
    parameter int COORD_BITS = abo_pkg::COORD_BITS_DEF,
    parameter int CMP_W      = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic [abo_pkg::DIM_W-1:0] frame_width,
    input  logic [abo_pkg::DIM_W-1:0] frame_height,
    input  logic [abo_pkg::POS_W-1:0] window_top,
    input  logic [abo_pkg::DIM_W-1:0] window_height,
    output logic [COORD_BITS-1:0]     col,
    output abo_pkg::pos_t             pos
);
    import abo_pkg::*;

    logic [COORD_BITS-1:0] column_count_reg;
    logic [COORD_BITS-1:0] column_count_next;
    logic [COORD_BITS-1:0] row_count_reg;
    logic [COORD_BITS-1:0] row_count_next;

    logic [CMP_W-1:0] col_w;
    logic [CMP_W-1:0] row_w;
    logic [CMP_W-1:0] col_step;
    logic [CMP_W-1:0] row_step;
    logic [CMP_W-1:0] row_bottom;

    assign col_w      = CMP_W'(column_count_reg);
    assign row_w      = CMP_W'(row_count_reg);
    assign col_step   = col_w + CMP_W'(LANES);
    assign row_step   = row_w + CMP_W'(1);
    assign row_bottom = CMP_W'(window_top) + CMP_W'(window_height);

    // row status
    always_comb begin
        pos.row_in    = (row_w >= CMP_W'(window_top)) && (row_w < row_bottom);
        pos.row_end   = col_step >= CMP_W'(frame_width);
        pos.frame_end = pos.row_end && (row_step >= CMP_W'(frame_height));
    end

    // next counter values
    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (pos.row_end) begin
            column_count_next = '0;
            row_count_next    = pos.frame_end ? '0 : row_step[COORD_BITS-1:0];
        end else begin
            column_count_next = col_step[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (advance) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    assign col = column_count_reg;

endmodule

[rtl/alpha_blend_overlay_compositor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_overlay_compositor_core
// Blends a foreground RGBA stream over a background RGB stream inside a
// programmable rectangle, four pixels a beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat carries four background pixels and the four aligned
//   foreground RGBA pixels, in raster order, lane 0 leftmost.
//   m_ channel: one beat per input beat with four blended RGB pixels and
//   row_end / frame_end flags.
//   cfg channel: register writes (index, data), always ready; write only while
//   the block is idle.
// Pipeline: two register stages, the product stage and the output register;
//   m_valid rises when the beat moves on from the product stage to the output.
// Throughput: one beat per cycle unless stalled; the four lanes blend in parallel,
//   each lane's per-channel 8x8 multiplies are registered before the final add.
// Reset: counters restart at column 0, row 0; registers return to their
//   defaults (800x600 frame, window 235x126 at 252,424); pipeline empties.
// Stall: when m_ready is low the output beat holds; if the product stage is
//   empty one more beat is taken into it, then s_ready drops until the output drains.
// ----------------------------------------------------------------------------
module alpha_blend_overlay_compositor_core #(
    parameter int COORD_BITS = abo_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_back_pixel_0,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_back_pixel_1,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_back_pixel_2,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_back_pixel_3,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_front_pixel_0,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_front_pixel_1,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_front_pixel_2,
    input  logic [abo_pkg::IN_PIX_W-1:0]    s_front_pixel_3,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [abo_pkg::OUT_PIX_W-1:0]   m_out_pixel_0,
    output logic [abo_pkg::OUT_PIX_W-1:0]   m_out_pixel_1,
    output logic [abo_pkg::OUT_PIX_W-1:0]   m_out_pixel_2,
    output logic [abo_pkg::OUT_PIX_W-1:0]   m_out_pixel_3,
    output logic                            m_row_end,
    output logic                            m_frame_end,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import abo_pkg::*;

    // compare width: holds column + lane offset and window edge sums
    localparam int CMP_W = ((COORD_BITS + 1) > (DIM_W + 1)) ? (COORD_BITS + 1) : (DIM_W + 1);

    // registers
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [POS_W-1:0] window_left_reg;
    logic [POS_W-1:0] window_top_reg;
    logic [DIM_W-1:0] window_width_reg;
    logic [DIM_W-1:0] window_height_reg;

    // pipeline control
    logic s1_valid_reg;
    logic s1_row_end_reg;
    logic s1_frame_end_reg;
    logic m_valid_reg;
    logic m_row_end_reg;
    logic m_frame_end_reg;
    logic out_free;
    logic accept;
    logic s1_adv;

    logic [COORD_BITS-1:0] col;
    pos_t                  pos;
    logic [CMP_W-1:0]      col_w;
    logic [CMP_W-1:0]      win_left;
    logic [CMP_W-1:0]      win_right;

    logic [IN_PIX_W-1:0]  back_pix  [LANES];
    logic [IN_PIX_W-1:0]  front_pix [LANES];
    logic [OUT_PIX_W-1:0] out_pix   [LANES];

    // register write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            window_left_reg   <= RST_WINDOW_LEFT;
            window_top_reg    <= RST_WINDOW_TOP;
            window_width_reg  <= RST_WINDOW_WIDTH;
            window_height_reg <= RST_WINDOW_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[DIM_W-1:0];
                CFG_WINDOW_LEFT:   window_left_reg   <= cfg_data[POS_W-1:0];
                CFG_WINDOW_TOP:    window_top_reg    <= cfg_data[POS_W-1:0];
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and stage advance
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign s1_adv   = s1_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // row flags travel with the beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_row_end_reg   <= pos.row_end;
            s1_frame_end_reg <= pos.frame_end;
        end
        if (s1_adv) begin
            m_row_end_reg   <= s1_row_end_reg;
            m_frame_end_reg <= s1_frame_end_reg;
        end
    end

    // raster position
    abo_position #(
        .COORD_BITS (COORD_BITS),
        .CMP_W      (CMP_W)
    ) u_position (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (accept),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .window_top    (window_top_reg),
        .window_height (window_height_reg),
        .col           (col),
        .pos           (pos)
    );

    assign col_w     = CMP_W'(col);
    assign win_left  = CMP_W'(window_left_reg);
    assign win_right = CMP_W'(window_left_reg) + CMP_W'(window_width_reg);

    // lane mapping
    assign back_pix[0]  = s_back_pixel_0;
    assign back_pix[1]  = s_back_pixel_1;
    assign back_pix[2]  = s_back_pixel_2;
    assign back_pix[3]  = s_back_pixel_3;
    assign front_pix[0] = s_front_pixel_0;
    assign front_pix[1] = s_front_pixel_1;
    assign front_pix[2] = s_front_pixel_2;
    assign front_pix[3] = s_front_pixel_3;

    // blend lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        abo_lane #(
            .LANE_IDX (g),
            .CMP_W    (CMP_W)
        ) u_lane (
            .aclk        (aclk),
            .stage1_en   (accept),
            .stage2_en   (s1_adv),
            .col         (col_w),
            .win_left    (win_left),
            .win_right   (win_right),
            .row_in      (pos.row_in),
            .back_pixel  (back_pix[g]),
            .front_pixel (front_pix[g]),
            .out_pixel   (out_pix[g])
        );
    end

    // merged output beat
    assign m_valid       = m_valid_reg;
    assign m_out_pixel_0 = out_pix[0];
    assign m_out_pixel_1 = out_pix[1];
    assign m_out_pixel_2 = out_pix[2];
    assign m_out_pixel_3 = out_pix[3];
    assign m_row_end     = m_row_end_reg;
    assign m_frame_end   = m_frame_end_reg;

endmodule
